@@ rtl/pairwise_column_difference_ratio_defines.svh @@
// ----------------------------------------------------------------------------
// pairwise column difference ratio: assertion macros
// checking helpers, included only by the top level of the rtl modules
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_COLUMN_DIFFERENCE_RATIO_DEFINES_SVH
`define PAIRWISE_COLUMN_DIFFERENCE_RATIO_DEFINES_SVH

// checked only outside reset
`define PCDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define PCDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/pcdr_pkg.sv @@
// ----------------------------------------------------------------------------
// pcdr_pkg
// types and constants of the pairwise column difference ratio block
// ----------------------------------------------------------------------------
package pcdr_pkg;

  localparam int MAX_SAMPLES_DEF  = 32;
  localparam int MAX_FEATURES_DEF = 16;

  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;
  localparam int DVD_W   = VALUE_W + FRAC_W;
  localparam int RES_W   = 33;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 4;
  localparam int PAIR_W  = 7;
  localparam int SCNT_W  = 6;
  localparam int FCNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;
  localparam logic METHOD_DIFF  = 1'b0;
  localparam logic METHOD_DIV   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_METHOD   = 2'd0,
    CFG_SAMPLES  = 2'd1,
    CFG_FEATURES = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_CALC,
    S_DIV,
    S_EMIT,
    S_MARK,
    S_DONE
  } state_e;

endpackage

@@ rtl/pcdr_ram.sv @@
// ----------------------------------------------------------------------------
// pcdr_ram
// single port ram, one address per cycle (a write also reads the old word), registered read data
// ----------------------------------------------------------------------------
module pcdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pcdr_div.sv @@
// ----------------------------------------------------------------------------
// pcdr_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcdr_div
  import pcdr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [VALUE_W-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DVD_W-1:0]   quot_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0]   quot_q, quot_d;
  logic [VALUE_W-1:0] dvs_q, dvs_d;
  logic [VALUE_W:0]   trial;
  logic               fits;

  always_comb begin
    trial  = {rem_q, quot_q[DVD_W-1]};
    fits   = trial >= {1'b0, dvs_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
      rem_d  = '0;
      quot_d = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? VALUE_W'(trial - {1'b0, dvs_q}) : trial[VALUE_W-1:0];
      quot_d = {quot_q[DVD_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

@@ rtl/pairwise_column_difference_ratio.sv @@
// sequence: a load beat is written when accepted; a compute beat on an exhausted walk goes to
// S_DONE, else it reads each sample row in S_RD_A and S_RD_B, then S_CALC (S_DIV in division
// mode, nonzero divisor), S_EMIT per entry, S_MARK per marker; output stalls hold all three
// throughput: one beat at a time, set by the single ram port (two reads per row) and the
// serial divider. reset: clears control, pair walk and registers
// (method 0, 32 samples, 16 features); matrix contents stay undefined until written
// ----------------------------------------------------------------------------
// pairwise_column_difference_ratio
// column difference or ratio engine over a ram-held sample by feature matrix
// ----------------------------------------------------------------------------
`include "pairwise_column_difference_ratio_defines.svh"

module pairwise_column_difference_ratio
  import pcdr_pkg::*;
#(
  parameter int MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // row_index, column_index, element_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // func
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // sample_row, pair_index, result_value
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // is_entry, all_done
  output logic [1:0]            m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DEPTH  = MAX_SAMPLES * MAX_FEATURES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SW     = $clog2(MAX_SAMPLES + 1);
  localparam int FW     = $clog2(MAX_FEATURES) + 1;

  state_e state_q, state_d;
  logic [SW-1:0]      k_q, k_d;
  logic [FW-1:0]      first_q, first_d, second_q, second_d;
  logic [PAIR_W-1:0]  pair_q, pair_d;
  logic               exh_q, exh_d;
  logic               method_q;
  logic [SCNT_W-1:0]  scnt_q;
  logic [FCNT_W-1:0]  fcnt_q;
  logic [VALUE_W-1:0] a_q, a_d;
  logic               neg_q, neg_d;
  logic [RES_W-1:0]   val_q, val_d;

  logic               ov_q;
  logic               o_entry_q, o_last_q, o_done_q;
  logic [ROW_W-1:0]   o_row_q;
  logic [PAIR_W-1:0]  o_pair_q;
  logic [RES_W-1:0]   o_val_q;

  logic               out_load, out_free;
  logic               n_entry, n_last, n_done;
  logic [ROW_W-1:0]   n_row;
  logic [PAIR_W-1:0]  n_pair;
  logic [RES_W-1:0]   n_val;

  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic [VALUE_W-1:0] in_value;
  logic               in_acc;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               div_start, div_busy, div_done;
  logic [DVD_W-1:0]   div_dvd, div_quot;
  logic [VALUE_W-1:0] abs_a, abs_b;
  logic               q_ok;

  logic [SW-1:0]      nsamp;
  logic [FW-1:0]      nfeat;
  logic [RES_W-1:0]   diff;

  assign in_row   = s_axis_tdata_i[ROW_W-1:0];
  assign in_col   = s_axis_tdata_i[ROW_W+COL_W-1:ROW_W];
  assign in_value = s_axis_tdata_i[ROW_W+COL_W+VALUE_W-1:ROW_W+COL_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !ov_q || m_axis_tready_i;

  // register values clamped into the legal range
  always_comb begin
    if (scnt_q == '0) begin
      nsamp = SW'(1);
    end else if (32'(scnt_q) > MAX_SAMPLES) begin
      nsamp = SW'(MAX_SAMPLES);
    end else begin
      nsamp = SW'(scnt_q);
    end
    if (32'(fcnt_q) < 2) begin
      nfeat = FW'(2);
    end else if (32'(fcnt_q) > MAX_FEATURES) begin
      nfeat = FW'(MAX_FEATURES);
    end else begin
      nfeat = FW'(fcnt_q);
    end
  end

  assign diff  = {a_q[VALUE_W-1], a_q} - {ram_rdata[VALUE_W-1], ram_rdata};
  assign abs_a = a_q[VALUE_W-1] ? VALUE_W'(-a_q) : a_q;
  assign abs_b = ram_rdata[VALUE_W-1] ? VALUE_W'(-ram_rdata) : ram_rdata;
  assign div_dvd = {abs_a, {FRAC_W{1'b0}}};
  assign q_ok = (div_quot != '0) &&
                (neg_q ? (div_quot <= DVD_W'(64'h8000_0000))
                       : (div_quot <= DVD_W'(64'h7FFF_FFFF)));

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    first_d   = first_q;
    second_d  = second_q;
    pair_d    = pair_q;
    exh_d     = exh_q;
    a_d       = a_q;
    neg_d     = neg_q;
    val_d     = val_q;
    ram_we    = 1'b0;
    ram_addr  = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    n_entry   = 1'b0;
    n_row     = '0;
    n_pair    = '0;
    n_val     = '0;
    n_last    = 1'b0;
    n_done    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        ram_addr = ADDR_W'(32'(in_row) * MAX_FEATURES + 32'(in_col));
        if (in_acc) begin
          if (s_axis_tuser_i == FUNC_LOAD) begin
            ram_we   = (32'(in_row) < MAX_SAMPLES) && (32'(in_col) < MAX_FEATURES);
            first_d  = '0;
            second_d = FW'(1);
            pair_d   = '0;
            exh_d    = 1'b0;
          end else begin
            k_d = '0;
            if (exh_q || second_q >= nfeat || first_q >= second_q) begin
              state_d = S_DONE;
            end else begin
              state_d = S_RD_A;
            end
          end
        end
      end
      S_RD_A: begin
        ram_addr = ADDR_W'(32'(k_q) * MAX_FEATURES + 32'(first_q));
        state_d  = S_RD_B;
      end
      S_RD_B: begin
        ram_addr = ADDR_W'(32'(k_q) * MAX_FEATURES + 32'(second_q));
        a_d      = ram_rdata;
        state_d  = S_CALC;
      end
      S_CALC: begin
        if (method_q == METHOD_DIFF) begin
          val_d   = diff;
          state_d = (diff != '0) ? S_EMIT : S_MARK;
        end else begin
          val_d   = '0;
          state_d = S_MARK;
          if (ram_rdata != '0) begin
            div_start = 1'b1;
            neg_d     = a_q[VALUE_W-1] ^ ram_rdata[VALUE_W-1];
            state_d   = S_DIV;
          end
        end
        // no entry for this row: go on with the next one, if any
        if (state_d == S_MARK && k_q + 1'b1 < nsamp) begin
          k_d     = k_q + 1'b1;
          state_d = S_RD_A;
        end
      end
      S_DIV: begin
        if (div_done) begin
          val_d = neg_q ? RES_W'(-div_quot) : RES_W'(div_quot);
          if (q_ok) begin
            state_d = S_EMIT;
          end else if (k_q + 1'b1 < nsamp) begin
            k_d     = k_q + 1'b1;
            state_d = S_RD_A;
          end else begin
            state_d = S_MARK;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          n_entry  = 1'b1;
          n_row    = ROW_W'(k_q);
          n_pair   = pair_q;
          n_val    = val_q;
          if (k_q + 1'b1 < nsamp) begin
            k_d     = k_q + 1'b1;
            state_d = S_RD_A;
          end else begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_load = 1'b1;
          n_pair   = pair_q;
          n_last   = 1'b1;
          pair_d   = pair_q + 1'b1;
          second_d = second_q + 1'b1;
          if (second_q + 1'b1 >= nfeat) begin
            first_d  = first_q + 1'b1;
            second_d = first_q + FW'(2);
            exh_d    = (first_q + FW'(2) >= nfeat);
          end
          state_d = S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          n_last   = 1'b1;
          n_done   = 1'b1;
          exh_d    = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      first_q  <= '0;
      second_q <= FW'(1);
      pair_q   <= '0;
      exh_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      first_q  <= first_d;
      second_q <= second_d;
      pair_q   <= pair_d;
      exh_q    <= exh_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_DIFF;
      scnt_q   <= SCNT_W'(32);
      fcnt_q   <= FCNT_W'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_METHOD:   method_q <= cfg_data_i[0];
        CFG_SAMPLES:  scnt_q   <= cfg_data_i[SCNT_W-1:0];
        CFG_FEATURES: fcnt_q   <= cfg_data_i[FCNT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    neg_q <= neg_d;
    val_q <= val_d;
    if (out_load) begin
      o_entry_q <= n_entry;
      o_row_q   <= n_row;
      o_pair_q  <= n_pair;
      o_val_q   <= n_val;
      o_last_q  <= n_last;
      o_done_q  <= n_done;
    end
  end

  pcdr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_value),
    .rdata_o (ram_rdata)
  );

  pcdr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (abs_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-ROW_W-PAIR_W-RES_W){1'b0}}, o_val_q, o_pair_q, o_row_q};
  assign m_axis_tuser_o  = {o_done_q, o_entry_q};
  assign m_axis_tlast_o  = o_last_q;

  `PCDR_ASSERT(a_div_state, div_busy |-> state_q == S_DIV, "divider busy outside divide state")
  `PCDR_ASSERT(a_entry_nonzero, (m_axis_tvalid_o && o_entry_q) |-> o_val_q != '0,
               "sparse entry with zero value")
  `PCDR_ASSERT(a_marker_last, (m_axis_tvalid_o && !o_entry_q) |-> o_last_q,
               "end marker without last")
  `PCDR_ASSERT(a_no_overwrite, out_load |-> out_free, "output beat overwritten")
  `PCDR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o,
                      "output valid right after reset")

endmodule

@@ tb/tb_pairwise_column_difference_ratio.sv @@
// ----------------------------------------------------------------------------
// tb_pairwise_column_difference_ratio
// streams load and compute beats into the pair engine, predicts every sparse
// entry and marker in a behavioral model and checks them in order, with random
// gaps on both sides, one long output hold-off and several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pairwise_column_difference_ratio;
  import pcdr_pkg::*;

  typedef struct packed {
    logic        func;
    logic [4:0]  row;
    logic [3:0]  col;
    logic [31:0] val;
  } elem_beat_t;

  typedef struct packed {
    logic        is_entry;
    logic [4:0]  row;
    logic [6:0]  pair;
    logic [32:0] val;
    logic        last;
    logic        done;
  } pair_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [IN_DATA_W-1:0] s_axis_tdata_i;
  logic s_axis_tuser_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  elem_beat_t   s_beat = '0;
  elem_beat_t   pending_beats_q[$];
  pair_result_t expected_results_q[$];

  // engine copy
  logic [31:0] matrix_mdl[512];
  int          first_col, second_col;
  logic [6:0]  pair_cnt;
  logic        walk_done;
  logic        method_mdl;
  logic [5:0]  samples_mdl;
  logic [4:0]  features_mdl;

  logic s_fire = 1'b0, m_fire = 1'b0;
  int   s_gap = 0, m_gap = 0, hold_cnt = 0;
  logic no_idle = 1'b0, hold_req = 1'b0, hold_taken = 1'b0;
  int   quiet_cycles = 0;
  int   fail_cnt = 0;

  assign s_axis_tdata_i = {7'd0, s_beat.val, s_beat.col, s_beat.row};
  assign s_axis_tuser_i = s_beat.func;

  pairwise_column_difference_ratio dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void restart_walk();
    first_col = 0;
    second_col = 1;
    pair_cnt = '0;
    walk_done = 1'b0;
  endfunction

  function automatic void add_expected(pair_result_t r);
    expected_results_q.insert(expected_results_q.size(), r);
  endfunction

  function automatic void add_pending(elem_beat_t b);
    pending_beats_q.insert(pending_beats_q.size(), b);
  endfunction

  function automatic void predict_pair_results(elem_beat_t b);
    int ns, nf, k;
    longint a, d, v;
    if (b.func == FUNC_LOAD) begin
      matrix_mdl[{b.row, b.col}] = b.val;
      restart_walk();
      return;
    end
    ns = (samples_mdl < 1) ? 1 : ((samples_mdl > 32) ? 32 : samples_mdl);
    nf = (features_mdl < 2) ? 2 : ((features_mdl > 16) ? 16 : features_mdl);
    if (walk_done || second_col >= nf || first_col >= second_col) begin
      walk_done = 1'b1;
      add_expected('{1'b0, 5'd0, 7'd0, 33'd0, 1'b1, 1'b1});
      return;
    end
    for (k = 0; k < ns; k++) begin
      a = longint'($signed(matrix_mdl[k*16 + first_col]));
      d = longint'($signed(matrix_mdl[k*16 + second_col]));
      if (method_mdl == METHOD_DIFF) begin
        v = a - d;
        if (v == 0) continue;
      end else begin
        if (d == 0) continue;
        v = (a * 65536) / d;
        if (v > 64'sd2147483647 || v < -64'sd2147483648 || v == 0) continue;
      end
      add_expected('{1'b1, k[4:0], pair_cnt, v[32:0], 1'b0, 1'b0});
    end
    add_expected('{1'b0, 5'd0, pair_cnt, 33'd0, 1'b1, 1'b0});
    pair_cnt = pair_cnt + 7'd1;
    second_col++;
    if (second_col >= nf) begin
      first_col++;
      second_col = first_col + 1;
      if (second_col >= nf) walk_done = 1'b1;
    end
  endfunction

  // handshakes, prediction, checking and watchdog
  always @(posedge clk_i) begin
    pair_result_t got, want;
    s_fire <= s_axis_tvalid_i && s_axis_tready_o;
    m_fire <= m_axis_tvalid_o && m_axis_tready_i;
    if (s_axis_tvalid_i && s_axis_tready_o) predict_pair_results(s_beat);
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got = '{m_axis_tuser_o[0], m_axis_tdata_o[4:0], m_axis_tdata_o[11:5],
              m_axis_tdata_o[44:12], m_axis_tlast_o, m_axis_tuser_o[1]};
      if (expected_results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        fail_cnt++;
      end else begin
        want = expected_results_q.pop_front();
        if (got.is_entry !== want.is_entry) begin
          $display("%0t: is_entry exp %0d got %0d", $time, want.is_entry, got.is_entry);
          fail_cnt++;
        end
        if (got.row !== want.row) begin
          $display("%0t: sample_row exp %0d got %0d", $time, want.row, got.row);
          fail_cnt++;
        end
        if (got.pair !== want.pair) begin
          $display("%0t: pair_index exp %0d got %0d", $time, want.pair, got.pair);
          fail_cnt++;
        end
        if (got.val !== want.val) begin
          $display("%0t: result_value exp %h got %h", $time, want.val, got.val);
          fail_cnt++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
          fail_cnt++;
        end
        if (got.done !== want.done) begin
          $display("%0t: all_done exp %0d got %0d", $time, want.done, got.done);
          fail_cnt++;
        end
      end
    end
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || s_fire)) begin
      if (s_gap != 0) begin
        s_gap <= s_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_beats_q.size() != 0) begin
        s_beat <= pending_beats_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_gap <= no_idle ? 0 : $urandom_range(0, 7);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // output ready, with a one-time long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready_i <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt <= 400;
        m_axis_tready_i <= 1'b0;
      end else if (!m_axis_tready_i || m_fire) begin
        if (m_gap != 0) begin
          m_gap <= m_gap - 1;
          m_axis_tready_i <= 1'b0;
        end else begin
          m_axis_tready_i <= 1'b1;
          if (m_axis_tready_i) m_gap <= no_idle ? 0 : $urandom_range(0, 7);
        end
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 8))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'h0001_0000;
      4: return 32'hffff_0000;
      5: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(int r, int c, logic [31:0] v);
    add_pending('{FUNC_LOAD, r[4:0], c[3:0], v});
  endtask

  task automatic push_compute(int n);
    repeat (n) add_pending('{FUNC_COMPUTE, 5'($urandom), 4'($urandom), $urandom});
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_METHOD:   method_mdl = d[0];
      CFG_SAMPLES:  samples_mdl = d;
      CFG_FEATURES: features_mdl = d[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_mode(logic m, int ns, int nf);
    write_reg(CFG_METHOD, CFG_DATA_W'(m));
    write_reg(CFG_SAMPLES, ns[5:0]);
    write_reg(CFG_FEATURES, nf[5:0]);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_beats_q.size() != 0 || s_axis_tvalid_i || expected_results_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    int r, c, n;
    for (int i = 0; i < 512; i++) matrix_mdl[i] = '0;
    restart_walk();
    method_mdl = METHOD_DIFF;
    samples_mdl = 6'd32;
    features_mdl = 5'd16;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill every element that a later compute reads: columns 0 and 1 of all
    // rows, columns 2 to 4 of rows 0 to 3
    set_mode(METHOD_DIFF, 4, 3);
    for (r = 0; r < 32; r++)
      for (c = 0; c < 2; c++) push_load(r, c, pick_value());
    for (r = 0; r < 4; r++)
      for (c = 2; c < 5; c++) push_load(r, c, pick_value());
    push_load(0, 0, 32'h0000_0005);
    push_load(0, 1, 32'h0000_0005);
    push_compute(4);
    drain();

    // division corner rows: zero denominator, overflow, truncation to zero
    no_idle = 1'b1;
    set_mode(METHOD_DIV, 4, 4);
    push_load(0, 0, 32'h7fff_ffff); push_load(0, 1, 32'h0000_0001);
    push_load(1, 0, 32'h0001_0000); push_load(1, 1, 32'h0000_0000);
    push_load(2, 0, 32'h0000_0001); push_load(2, 1, 32'h7fff_ffff);
    push_load(3, 0, 32'h8000_0000); push_load(3, 1, 32'hffff_0000);
    push_compute(4);
    drain();
    no_idle = 1'b0;

    set_mode(METHOD_DIV, 32, 2);
    push_compute(2);
    drain();

    // all rows of one pair, with the output held off for a while
    set_mode(METHOD_DIFF, 32, 2);
    hold_req = 1'b1;
    push_load(31, 1, $urandom);
    push_compute(4);
    drain();

    // shrinking the feature count strands the current pair
    no_idle = 1'b1;
    set_mode(METHOD_DIFF, 1, 16);
    push_load(0, 3, pick_value());
    push_compute(3);
    drain();
    write_reg(CFG_FEATURES, 6'd3);
    push_compute(2);
    drain();
    no_idle = 1'b0;

    // register values outside the legal range saturate
    set_mode(METHOD_DIFF, 0, 0);
    push_load(0, 2, pick_value());
    push_compute(3);
    drain();
    set_mode(METHOD_DIV, 63, 31);
    push_load(5, 5, pick_value());
    push_compute(1);
    drain();

    // random phases inside the filled region
    for (int p = 0; p < 2; p++) begin
      no_idle = (p == 1);
      set_mode(1'($urandom_range(0, 1)), $urandom_range(1, 4), $urandom_range(2, 5));
      push_load($urandom_range(0, 3), $urandom_range(0, 4), pick_value());
      n = 0;
      while (n < 6) begin
        if ($urandom_range(0, 9) == 0)
          push_load($urandom_range(0, 3), $urandom_range(0, 4), pick_value());
        else
          push_compute(1);
        n++;
      end
      drain();
    end

    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
